// ===== rtl/ps2mrb_pkg.sv =====
`default_nettype none

package ps2mrb_pkg;

    // Input function codes
    localparam logic [1:0] FUNC_MOVE    = 2'd0;
    localparam logic [1:0] FUNC_BUTTONS = 2'd1;
    localparam logic [1:0] FUNC_POLL    = 2'd2;
    localparam logic [1:0] FUNC_CLEAR   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_SCALING     = 2'd0;
    localparam logic [1:0] CFG_RESOLUTION  = 2'd1;
    localparam logic [1:0] CFG_PACKET_KIND = 2'd2;

    // Packet kinds
    localparam logic [1:0] PKT_STANDARD    = 2'd0;
    localparam logic [1:0] PKT_WHEEL       = 2'd1;
    localparam logic [1:0] PKT_FIVE_BUTTON = 2'd2;

    localparam int CLAMP_LIMIT = 255;
    localparam int WHEEL_HI    = 7;
    localparam int WHEEL_LO    = -8;

    localparam logic [7:0] STATUS_BASE     = 8'b0000_1000;
    localparam logic [7:0] STATUS_Y_SIGN   = 8'b0010_0000;
    localparam logic [7:0] STATUS_X_SIGN   = 8'b0001_0000;
    localparam logic [7:0] BTN45_MASK      = 8'b0011_0000;
    localparam logic [7:0] WHEEL_NIB_MASK  = 8'b0000_1111;
    localparam logic [7:0] STATUS_BTN_MASK = 8'h07;

    localparam logic [2:0] LEN_SHORT = 3'd3;
    localparam logic [2:0] LEN_LONG  = 3'd4;

    // 2:1 scaling curve for |v| < 6, indexed by v + 5
    localparam logic signed [4:0] SCALE_CURVE [11] = '{
        -5'sd9, -5'sd6, -5'sd3, -5'sd1, -5'sd1, 5'sd0,
        5'sd1, 5'sd1, 5'sd3, 5'sd6, 5'sd9
    };

    typedef enum logic [1:0] {
        CMD_MOVE,
        CMD_BUTTONS,
        CMD_POLL,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dw;
        logic [7:0]         mask;
    } cmd_t;

    typedef struct packed {
        logic       scaling_double;
        logic [1:0] resolution_code;
        logic [1:0] packet_kind;
    } cfg_t;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [7:0] x_byte;
        logic [7:0] y_byte;
        logic [7:0] extra_byte;
        logic [2:0] packet_length;
    } pkt_t;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) begin
            return 16'sh7FFF;
        end
        if (v < -18'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ps2mrb_front.sv =====
`default_nettype none

module ps2mrb_front (
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         func,
    input  wire logic signed [15:0] move_x,
    input  wire logic signed [15:0] move_y,
    input  wire logic signed [15:0] move_wheel,
    input  wire logic [7:0]         button_mask,
    output logic                    push_valid,
    input  wire logic               push_ready,
    output ps2mrb_pkg::cmd_t        push_cmd
);
    import ps2mrb_pkg::*;

    logic keep;

    always_comb
    begin
        push_cmd.dx   = move_x;
        push_cmd.dy   = move_y;
        push_cmd.dw   = move_wheel;
        push_cmd.mask = button_mask;
        keep          = 1'b1;
        case (func)
            FUNC_MOVE:
            begin
                push_cmd.kind = CMD_MOVE;
                // an all-zero move changes nothing, so it never enters the queue
                keep = (move_x != 16'sd0) || (move_y != 16'sd0) || (move_wheel != 16'sd0);
            end
            FUNC_BUTTONS: push_cmd.kind = CMD_BUTTONS;
            FUNC_POLL:    push_cmd.kind = CMD_POLL;
            FUNC_CLEAR:   push_cmd.kind = CMD_CLEAR;
            default:      push_cmd.kind = CMD_CLEAR;
        endcase
    end

    assign in_ready   = push_ready;
    assign push_valid = in_valid && keep;

endmodule

`default_nettype wire

// ===== rtl/ps2mrb_queue.sv =====
`default_nettype none

module ps2mrb_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire ps2mrb_pkg::cmd_t  push_cmd,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output ps2mrb_pkg::cmd_t       pop_cmd
);
    import ps2mrb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ps2mrb_back.sv =====
`default_nettype none

module ps2mrb_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ps2mrb_pkg::cfg_t  cfg,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire ps2mrb_pkg::cmd_t  cmd,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ps2mrb_pkg::pkt_t       pkt
);
    import ps2mrb_pkg::*;

    function automatic logic signed [8:0] clamp_axis(input logic signed [15:0] v);
        if (v > 16'(CLAMP_LIMIT)) begin
            return 9'(CLAMP_LIMIT);
        end
        if (v < -16'sd1 * 16'(CLAMP_LIMIT)) begin
            return -9'sd1 * 9'(CLAMP_LIMIT);
        end
        return v[8:0];
    endfunction

    function automatic logic axis_clipped(input logic signed [15:0] v);
        return (v > 16'(CLAMP_LIMIT)) || (v < -16'sd1 * 16'(CLAMP_LIMIT));
    endfunction

    function automatic logic signed [8:0] clamp_wheel(input logic signed [15:0] v);
        if (v > 16'(WHEEL_HI)) begin
            return 9'(WHEEL_HI);
        end
        if (v < 16'(WHEEL_LO)) begin
            return 9'(WHEEL_LO);
        end
        return v[8:0];
    endfunction

    // accumulator minus the reported value scaled back up
    function automatic logic signed [15:0] take_rest(input logic signed [15:0] acc,
                                                     input logic signed [8:0]  v,
                                                     input logic [1:0]         d);
        logic signed [17:0] diff;
        diff = 18'(acc) - (18'(v) <<< d);
        return sat16(diff);
    endfunction

    function automatic logic signed [9:0] scale_axis(input logic signed [8:0] v);
        logic [8:0] idx;
        idx = v + 9'sd5;
        if (v > -9'sd6 && v < 9'sd6) begin
            return 10'(SCALE_CURVE[idx[3:0]]);
        end
        return {v, 1'b0};
    endfunction

    logic signed [15:0] accum_x_reg, accum_x_next;
    logic signed [15:0] accum_y_reg, accum_y_next;
    logic signed [15:0] accum_w_reg, accum_w_next;
    logic [7:0]         button_reg, button_next;
    logic               pending_reg, pending_next;
    logic               out_valid_reg, out_valid_next;
    pkt_t               pkt_reg, pkt_next;

    logic [1:0]         shift_amt;
    logic signed [15:0] sh_x, sh_y;
    logic signed [8:0]  x_v, y_v, w_v;
    logic signed [9:0]  x_rep, y_rep, y_neg;
    logic [7:0]         nw;
    logic               has_result, out_free, do_cmd;

    assign out_free   = !out_valid_reg || out_ready;
    assign has_result = (cmd.kind == CMD_POLL) && pending_reg;
    assign cmd_ready  = out_free || !has_result;
    assign do_cmd     = cmd_valid && cmd_ready;

    assign shift_amt = 2'd3 - cfg.resolution_code;
    assign sh_x      = accum_x_reg >>> shift_amt;
    assign sh_y      = accum_y_reg >>> shift_amt;
    assign x_v       = clamp_axis(sh_x);
    assign y_v       = clamp_axis(sh_y);
    assign w_v       = clamp_wheel(accum_w_reg);
    assign x_rep     = cfg.scaling_double ? scale_axis(x_v) : 10'(x_v);
    assign y_rep     = cfg.scaling_double ? scale_axis(y_v) : 10'(y_v);
    assign y_neg     = -y_rep;
    assign nw        = 8'(-w_v);

    always_comb
    begin
        accum_x_next   = accum_x_reg;
        accum_y_next   = accum_y_reg;
        accum_w_next   = accum_w_reg;
        button_next    = button_reg;
        pending_next   = pending_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pkt_next       = pkt_reg;

        if (do_cmd) begin
            case (cmd.kind)
                CMD_MOVE:
                begin
                    accum_x_next = sat16(18'(accum_x_reg) + 18'(cmd.dx));
                    accum_y_next = sat16(18'(accum_y_reg) + 18'(cmd.dy));
                    accum_w_next = sat16(18'(accum_w_reg) + 18'(cmd.dw));
                    pending_next = 1'b1;
                end
                CMD_BUTTONS:
                begin
                    if (button_reg != cmd.mask) begin
                        button_next  = cmd.mask;
                        pending_next = 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    accum_x_next = '0;
                    accum_y_next = '0;
                    accum_w_next = '0;
                end
                CMD_POLL:
                begin
                    if (pending_reg) begin
                        accum_x_next = take_rest(accum_x_reg, x_v, shift_amt);
                        accum_y_next = take_rest(accum_y_reg, y_v, shift_amt);
                        accum_w_next = take_rest(accum_w_reg, w_v, 2'd0);
                        // leftover after a clip keeps the update pending
                        pending_next = axis_clipped(sh_x) || axis_clipped(sh_y)
                                       || (accum_w_reg > 16'(WHEEL_HI))
                                       || (accum_w_reg < 16'(WHEEL_LO));
                        out_valid_next = 1'b1;
                        pkt_next.status_byte = STATUS_BASE | (button_reg & STATUS_BTN_MASK)
                                               | (y_neg[9] ? STATUS_Y_SIGN : 8'h00)
                                               | (x_rep[9] ? STATUS_X_SIGN : 8'h00);
                        pkt_next.x_byte = x_rep[7:0];
                        pkt_next.y_byte = y_neg[7:0];
                        case (cfg.packet_kind)
                            PKT_WHEEL:
                            begin
                                pkt_next.extra_byte    = nw;
                                pkt_next.packet_length = LEN_LONG;
                            end
                            PKT_FIVE_BUTTON:
                            begin
                                pkt_next.extra_byte    = (nw & WHEEL_NIB_MASK)
                                                         | ({button_reg[6:0], 1'b0} & BTN45_MASK);
                                pkt_next.packet_length = LEN_LONG;
                            end
                            default:
                            begin
                                pkt_next.extra_byte    = 8'h00;
                                pkt_next.packet_length = LEN_SHORT;
                            end
                        endcase
                    end
                end
                default:
                begin
                    pending_next = pending_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            accum_x_reg   <= '0;
            accum_y_reg   <= '0;
            accum_w_reg   <= '0;
            button_reg    <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            accum_x_reg   <= accum_x_next;
            accum_y_reg   <= accum_y_next;
            accum_w_reg   <= accum_w_next;
            button_reg    <= button_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_reg <= pkt_next;
    end

    assign out_valid = out_valid_reg;
    assign pkt       = pkt_reg;

endmodule

`default_nettype wire

// ===== rtl/ps2_mouse_report_builder_unit.sv =====
// PS/2 mouse report builder.
// Input channel (in_valid/in_ready): func with move_x/move_y/move_wheel and
// button_mask. Moves update the accumulators and button sets the buttons;
// clear zeroes the accumulators, and a poll with an update pending yields
// one packet on the output channel (out_valid/out_ready) as status/x/y/extra
// bytes plus packet_length. Other transactions produce nothing on the output.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// index 0 scaling, 1 resolution, 2 packet kind, other indexes are ignored.
// Write it only while the block is idle.
// With the queue empty, an accepted poll is first written into the command
// queue, then the back end loads the packet register from the queue head;
// queued transactions ahead of it and a stalled output delay the packet.
// Throughput: one transaction per cycle while the output is not stalled;
// the queue absorbs short stalls.
// When the receiver stalls, the packet holds in the output register, a poll
// with an update pending backs up the queue and in_ready drops once it is full.
// Reset clears accumulators, buttons, pending flag and queue; resolution
// resets to 3, scaling off, standard 3-byte packets.
`default_nettype none

module ps2_mouse_report_builder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         func,
    input  wire logic signed [15:0] move_x,
    input  wire logic signed [15:0] move_y,
    input  wire logic signed [15:0] move_wheel,
    input  wire logic [7:0]         button_mask,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              status_byte,
    output logic [7:0]              x_byte,
    output logic [7:0]              y_byte,
    output logic [7:0]              extra_byte,
    output logic [2:0]              packet_length,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [1:0]         cfg_data
);
    import ps2mrb_pkg::*;

    cfg_t cfg_reg, cfg_next;
    cmd_t push_cmd, pop_cmd;
    pkt_t pkt;
    logic push_valid, push_ready, pop_valid, pop_ready;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_SCALING:     cfg_next.scaling_double  = cfg_data[0];
                CFG_RESOLUTION:  cfg_next.resolution_code = cfg_data;
                CFG_PACKET_KIND: cfg_next.packet_kind     = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.scaling_double  <= 1'b0;
            cfg_reg.resolution_code <= 2'd3;
            cfg_reg.packet_kind     <= PKT_STANDARD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ps2mrb_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .move_x      (move_x),
        .move_y      (move_y),
        .move_wheel  (move_wheel),
        .button_mask (button_mask),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd)
    );

    ps2mrb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    ps2mrb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pkt       (pkt)
    );

    assign status_byte   = pkt.status_byte;
    assign x_byte        = pkt.x_byte;
    assign y_byte        = pkt.y_byte;
    assign extra_byte    = pkt.extra_byte;
    assign packet_length = pkt.packet_length;

endmodule

`default_nettype wire

// ===== rtl/ps2mrb_checker.sv =====
`default_nettype none

module ps2mrb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] status_byte,
    input wire logic [7:0] x_byte,
    input wire logic [7:0] y_byte,
    input wire logic [7:0] extra_byte,
    input wire logic [2:0] packet_length
);
    import ps2mrb_pkg::*;

    // stalled packet must hold
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status_byte)
            && $stable(x_byte) && $stable(y_byte) && $stable(extra_byte)
            && $stable(packet_length))
        else $error("output transaction changed while stalled");

    a_pkt_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status_byte[3]
            && (packet_length == LEN_SHORT || packet_length == LEN_LONG))
        else $error("malformed packet header or length");

    a_short_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_length == LEN_SHORT |-> extra_byte == 8'h00)
        else $error("3-byte packet carries extra byte");

endmodule

bind ps2_mouse_report_builder_unit ps2mrb_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status_byte   (status_byte),
    .x_byte        (x_byte),
    .y_byte        (y_byte),
    .extra_byte    (extra_byte),
    .packet_length (packet_length)
);

`default_nettype wire
